// ----- rtl/ist_pkg.sv -----
// Shared types and constants for the integer set table.
package ist_pkg;

   localparam int DATA_W = 32;

   typedef enum logic [1:0] {
      FUNC_INSERT = 2'd0,
      FUNC_REMOVE = 2'd1,
      FUNC_QUERY  = 2'd2
   } ist_func_type;

   // Per-cycle command broadcast to every cell of the chain.
   typedef struct packed {
      logic shift;
      logic write;
   } ist_cell_ctl_type;

endpackage

// ----- rtl/ist_cell.sv -----
// One storage cell of the chain: holds one set entry and hands it to its lower neighbor.
module ist_cell #(
   parameter int IW    = 4,
   parameter int INDEX = 0
) (
   input  logic                       clock,
   input  ist_pkg::ist_cell_ctl_type  ctl,
   input  logic [IW-1:0]              bcast_idx,
   input  logic [ist_pkg::DATA_W-1:0] bcast_data,
   input  logic [ist_pkg::DATA_W-1:0] next_data,
   output logic [ist_pkg::DATA_W-1:0] cell_data
);
   import ist_pkg::*;

   localparam logic [IW-1:0] MY_IDX = IW'(INDEX);

   logic [DATA_W-1:0] data_ff;
   logic [DATA_W-1:0] data_in;
   logic              selected;

   assign selected = (bcast_idx == MY_IDX);

   // During a rotation every cell takes its upper neighbor, except the tail cell,
   // which takes the entry that leaves the head of the chain.
   always_comb begin
      data_in = data_ff;
      if (ctl.shift) begin
         data_in = selected ? bcast_data : next_data;
      end else if (ctl.write && selected) begin
         data_in = bcast_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign cell_data = data_ff;

endmodule

// ----- rtl/integer_set_table.sv -----
// Integer set table: a bounded set of signed 32-bit values held in a chain of cells.
//
// Input channel (req_): one operation per beat. req_func selects insert, remove or
// membership query (code three acts as a query); req_value is the element.
// Result channel (rsp_): one beat per operation, in order: whether the value was
// present before the operation, the element count afterwards, and a flag for an
// insert of an absent value into a full table, which is dropped.
// Each operation rotates the held entries once through the chain, one cell step
// per cycle, comparing the entry at the head cell. A removal is done by leaving
// the matching entry out of the rotation. An item is accepted only in the idle
// state, so the next item is not taken before the last result is written to the
// output register. The input is accepted again while that finished result still
// waits on the output register; that item then waits at its end until the result
// is taken.
// Synchronous reset empties the set and drops any pending result; entry contents
// are not cleared, since only entries below the count are ever read.
module integer_set_table #(
   parameter int CAPACITY = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [1:0]                         req_func,
   input  logic signed [31:0]                 req_value,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_was_present,
   output logic [$clog2(CAPACITY+1)-1:0]      rsp_count_after,
   output logic                               rsp_insert_dropped
);
   import ist_pkg::*;

   localparam int IW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(CAPACITY);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DONE
   } state_type;

   state_type         state_ff, state_in;
   ist_func_type      op_ff, op_in;
   logic [DATA_W-1:0] value_ff, value_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [CW-1:0]     steps_ff, steps_in;
   logic              found_ff, found_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_present_ff, rsp_present_in;
   logic [CW-1:0]     rsp_count_ff, rsp_count_in;
   logic              rsp_dropped_ff, rsp_dropped_in;

   ist_cell_ctl_type  cell_ctl;
   logic [IW-1:0]     bcast_idx;
   logic [DATA_W-1:0] bcast_data;
   logic [DATA_W-1:0] cell_data [CAPACITY];
   logic [CW-1:0]     tail_pos;
   logic              head_hit;
   logic              rsp_free;
   logic              is_insert;
   logic              insert_add;
   logic              insert_drop;

   genvar g;
   generate
      for (g = 0; g < CAPACITY; g++) begin : g_cell
         logic [DATA_W-1:0] upper_data;
         if (g == CAPACITY - 1) begin : g_last
            assign upper_data = bcast_data;
         end else begin : g_mid
            assign upper_data = cell_data[g+1];
         end
         ist_cell #(
            .IW    (IW),
            .INDEX (g)
         ) u_cell (
            .clock      (clock),
            .ctl        (cell_ctl),
            .bcast_idx  (bcast_idx),
            .bcast_data (bcast_data),
            .next_data  (upper_data),
            .cell_data  (cell_data[g])
         );
      end
   endgenerate

   assign tail_pos    = count_ff - CW'(1);
   assign head_hit    = (cell_data[0] == value_ff);
   assign rsp_free    = !rsp_valid_ff || rsp_ready;
   assign is_insert   = (op_ff == FUNC_INSERT);
   assign insert_drop = is_insert && !found_ff && (count_ff == FULL_COUNT);
   assign insert_add  = is_insert && !found_ff && (count_ff != FULL_COUNT);

   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      value_in       = value_ff;
      count_in       = count_ff;
      steps_in       = steps_ff;
      found_in       = found_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_present_in = rsp_present_ff;
      rsp_count_in   = rsp_count_ff;
      rsp_dropped_in = rsp_dropped_ff;
      cell_ctl       = '0;
      bcast_idx      = tail_pos[IW-1:0];
      bcast_data     = cell_data[0];

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in    = ist_func_type'(req_func);
               value_in = req_value;
               steps_in = count_ff;
               found_in = 1'b0;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (steps_ff != '0) begin
               cell_ctl.shift = 1'b1;
               steps_in       = steps_ff - CW'(1);
               if (head_hit) begin
                  found_in = 1'b1;
                  // A removed entry is simply not fed back to the tail.
                  if (op_ff == FUNC_REMOVE) begin
                     count_in = tail_pos;
                  end
               end
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               cell_ctl.write = insert_add;
               bcast_idx      = count_ff[IW-1:0];
               bcast_data     = value_ff;
               count_in       = insert_add ? count_ff + CW'(1) : count_ff;
               rsp_valid_in   = 1'b1;
               rsp_present_in = found_ff;
               rsp_count_in   = count_in;
               rsp_dropped_in = insert_drop;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff          <= op_in;
      value_ff       <= value_in;
      steps_ff       <= steps_in;
      found_ff       <= found_in;
      rsp_present_ff <= rsp_present_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_dropped_ff <= rsp_dropped_in;
   end

   assign req_ready          = (state_ff == ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_was_present    = rsp_present_ff;
   assign rsp_count_after    = rsp_count_ff;
   assign rsp_insert_dropped = rsp_dropped_ff;

endmodule

// ----- rtl/ist_checker.sv -----
// Port-level assertions for the integer set table, bound to the top level.
module ist_checker #(
   parameter int CAPACITY = 16
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic [1:0]                    req_func,
   input logic signed [31:0]            req_value,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic                          rsp_was_present,
   input logic [$clog2(CAPACITY+1)-1:0] rsp_count_after,
   input logic                          rsp_insert_dropped
);
   import ist_pkg::*;

   localparam int CW = $clog2(CAPACITY + 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(CAPACITY);

   logic [CW-1:0] last_count_ff;
   logic          req_beat;

   assign req_beat = req_valid && req_ready && (req_func != 2'(FUNC_QUERY) || req_value[0] == 1'b0
                     || req_value[0] == 1'b1);

   // Count reported by the most recently delivered result beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         last_count_ff <= '0;
      end else if (rsp_valid && rsp_ready) begin
         last_count_ff <= rsp_count_after;
      end
   end

   a_no_rsp_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat shown right after reset");

   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_was_present)
         && $stable(rsp_count_after) && $stable(rsp_insert_dropped))
      else $error("stalled result beat changed");

   a_drop_only_when_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_insert_dropped |-> !rsp_was_present && rsp_count_after == FULL_COUNT)
      else $error("dropped insert reported without a full table");

   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_count_after <= FULL_COUNT)
      else $error("count beyond capacity");

   a_count_steps_by_one: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_count_after == last_count_ff
         || rsp_count_after == last_count_ff + CW'(1)
         || rsp_count_after == last_count_ff - CW'(1)
         || req_beat)
      else $error("count moved by more than one between result beats");

endmodule

bind integer_set_table ist_checker #(.CAPACITY(CAPACITY)) u_ist_checker (.*);
